FILE: rtl/avpm_pkg.sv
// Package with shared types and constants of the voice pool mixer.
package avpm_pkg;

  localparam int unsigned Voices  = 16;
  localparam int unsigned VoiceW  = 4;
  localparam int unsigned LinkW   = 5;
  localparam int unsigned PosW    = 24;
  localparam int unsigned FpbW    = 13;
  localparam int unsigned FibW    = 12;
  localparam logic [LinkW-1:0] Nil = '1;
  localparam logic [FpbW-1:0] FpbReset = 13'd512;
  localparam logic [FpbW-1:0] FpbMax   = 13'd4096;

  typedef enum logic [2:0] {
    OpAdd     = 3'd0,
    OpRemove  = 3'd1,
    OpPlay    = 3'd2,
    OpPause   = 3'd3,
    OpRestart = 3'd4,
    OpClear   = 3'd5,
    OpFrame   = 3'd6,
    OpSample  = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    KindAck   = 2'd0,
    KindFetch = 2'd1,
    KindEnd   = 2'd2,
    KindMix   = 2'd3
  } kind_e;

  // One classified request as it travels from the front to the back.
  typedef struct packed {
    op_e              op;
    logic             vvalid;
    logic [VoiceW-1:0] voice;
    logic [PosW-1:0]  length;
    logic             play;
    logic             loop;
    logic signed [15:0] left;
    logic signed [15:0] right;
  } req_t;

  typedef struct packed {
    kind_e             kind;
    logic              ok;
    logic [VoiceW-1:0] voice;
    logic [PosW-1:0]   position;
    logic signed [15:0] mix_left;
    logic signed [15:0] mix_right;
    logic              last;
  } res_t;

  function automatic logic signed [15:0] sat_add16(logic signed [15:0] a,
                                                   logic signed [15:0] b);
    logic signed [16:0] s;
    s = 17'(a) + 17'(b);
    if (s > 17'sd32767) return 16'sh7fff;
    if (s < -17'sd32768) return 16'sh8000;
    return s[15:0];
  endfunction

endpackage

FILE: rtl/audio_voice_pool_mixer.sv
// Voice pool mixer: a two-entry request queue feeding the voice pool engine.
// A request is written into the queue and then taken by the engine, which
// registers its first result in the output register. Each non-frame request
// gives one result. A frame request walks the active voices (up to 16), at a
// buffer end walks them again, then gives its end result; the engine takes no
// new request until the frame is done, nor while its output holds an untaken result.
// Reset is asynchronous and active low; it empties the queue and rebuilds the free list.
module audio_voice_pool_mixer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration: frames per output buffer.
  input  logic                        cfg_we_i,
  input  logic [avpm_pkg::FpbW-1:0]   cfg_wdata_i,
  // Request channel.
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [2:0]                  op_i,
  input  logic [avpm_pkg::VoiceW-1:0] voice_i,
  input  logic [avpm_pkg::PosW-1:0]   length_frames_i,
  input  logic                        start_playing_i,
  input  logic                        loop_enable_i,
  input  logic signed [15:0]          sample_left_i,
  input  logic signed [15:0]          sample_right_i,
  // Result channel.
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  kind_o,
  output logic                        ok_o,
  output logic [avpm_pkg::VoiceW-1:0] voice_out_o,
  output logic [avpm_pkg::PosW-1:0]   position_o,
  output logic signed [15:0]          mix_left_o,
  output logic signed [15:0]          mix_right_o,
  output logic                        last_o
);

  logic [avpm_pkg::FpbW-1:0] fpb_q;
  logic                      q_valid, q_ready, busy;
  avpm_pkg::req_t            q_req;
  avpm_pkg::res_t            res;

  // The buffer-size register; the user must write it only while the block is idle, the block does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fpb_q <= avpm_pkg::FpbReset;
    end else if (cfg_we_i) begin
      fpb_q <= cfg_wdata_i;
    end
  end

  avpm_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .op_i,
    .voice_i,
    .length_frames_i,
    .start_playing_i,
    .loop_enable_i,
    .sample_left_i,
    .sample_right_i,
    .q_valid_o (q_valid),
    .q_ready_i (q_ready),
    .q_req_o   (q_req)
  );

  // The engine owns the voice tables and holds each result in its output register.
  avpm_back u_back (
    .clk_i,
    .rst_ni,
    .fpb_i       (fpb_q),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_req_i     (q_req),
    .out_valid_o,
    .out_ready_i,
    .out_res_o   (res),
    .busy_o      (busy)
  );

  assign kind_o      = res.kind;
  assign ok_o        = res.ok;
  assign voice_out_o = res.voice;
  assign position_o  = res.position;
  assign mix_left_o  = res.mix_left;
  assign mix_right_o = res.mix_right;
  assign last_o      = res.last;

  // Fetch results are never the final result of a frame request.
  a_fetch_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == avpm_pkg::KindFetch |-> !last_o)
    else $error("fetch marked last");

  // Only fetch results leave the last flag low.
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> kind_o == avpm_pkg::KindFetch)
    else $error("non-fetch result not last");

  // A pending result is visible through busy.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> busy)
    else $error("result pending while engine reports idle");

endmodule

FILE: rtl/avpm_front.sv
// Front end: takes requests, classifies them and queues them for the back end.
module avpm_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [2:0]                  op_i,
  input  logic [avpm_pkg::VoiceW-1:0] voice_i,
  input  logic [avpm_pkg::PosW-1:0]   length_frames_i,
  input  logic                        start_playing_i,
  input  logic                        loop_enable_i,
  input  logic signed [15:0]          sample_left_i,
  input  logic signed [15:0]          sample_right_i,
  output logic                        q_valid_o,
  input  logic                        q_ready_i,
  output avpm_pkg::req_t              q_req_o
);

  // Two-entry queue.
  avpm_pkg::req_t mem_q [2];
  logic           wr_q, wr_d, rd_q, rd_d;
  logic [1:0]     cnt_q, cnt_d;
  avpm_pkg::req_t req;
  logic           push, pop;

  always_comb begin
    req        = '0;
    req.op     = avpm_pkg::op_e'(op_i);
    req.vvalid = ({1'b0, voice_i} < (avpm_pkg::VoiceW+1)'(avpm_pkg::Voices));
    req.voice  = voice_i;
    req.length = length_frames_i;
    req.play   = start_playing_i;
    req.loop   = loop_enable_i;
    req.left   = sample_left_i;
    req.right  = sample_right_i;
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign pop        = q_valid_o && q_ready_i;
  assign q_req_o    = mem_q[rd_q];
  assign wr_d       = push ? ~wr_q : wr_q;
  assign rd_d       = pop ? ~rd_q : rd_q;
  assign cnt_d      = cnt_q + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= req;
    end
  end

endmodule

FILE: rtl/avpm_back.sv
// Back end: voice pool tables, list walks and mixing, with an output register.
module avpm_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [avpm_pkg::FpbW-1:0] fpb_i,
  input  logic                      q_valid_i,
  output logic                      q_ready_o,
  input  avpm_pkg::req_t            q_req_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output avpm_pkg::res_t            out_res_o,
  output logic                      busy_o
);

  localparam int unsigned N  = avpm_pkg::Voices;
  localparam int unsigned LW = avpm_pkg::LinkW;
  localparam int unsigned VW = avpm_pkg::VoiceW;
  localparam int unsigned PW = avpm_pkg::PosW;

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StWalk  = 4'b0010,
    StWrap  = 4'b0100,
    StEnd   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [LW-1:0] next_q [N];
  logic [LW-1:0] prev_q [N];
  logic [N-1:0]  used_q, play_q, loop_q;
  logic [PW-1:0] len_q [N];
  logic [PW-1:0] pos_q [N];
  logic [LW-1:0] ahead_q, fhead_q;
  logic [LW-1:0] cnt_q;
  logic [avpm_pkg::FibW-1:0] fib_q;
  logic signed [15:0] mixl_q, mixr_q;

  logic [LW-1:0]  h_q;
  logic [LW-1:0]  steps_q;
  logic [avpm_pkg::FibW-1:0] idx_q;
  logic           ovalid_q;
  avpm_pkg::res_t ores_q;

  avpm_pkg::req_t rq;
  logic           take;
  logic           out_free;
  logic [VW-1:0]  hv;
  logic           h_ok;
  logic [avpm_pkg::FpbW-1:0] eff;
  logic [avpm_pkg::FpbW-1:0] fib_inc;

  assign rq        = q_req_i;
  assign out_free  = !ovalid_q || out_ready_i;
  assign q_ready_o = (state_q == StIdle) && out_free;
  assign take      = q_valid_i && q_ready_o;
  assign hv        = h_q[VW-1:0];
  assign h_ok      = (h_q < LW'(N)) && (steps_q < LW'(N));
  assign out_valid_o = ovalid_q;
  assign out_res_o   = ores_q;
  assign busy_o      = (state_q != StIdle) || ovalid_q;

  always_comb begin
    eff = fpb_i;
    if (eff == '0) eff = avpm_pkg::FpbW'(1);
    if (eff > avpm_pkg::FpbMax) eff = avpm_pkg::FpbMax;
    fib_inc = {1'b0, fib_q} + avpm_pkg::FpbW'(1);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (take && rq.op == avpm_pkg::OpFrame) state_d = StWalk;
      StWalk: if (!h_ok) state_d = (fib_inc >= eff) ? StWrap : StEnd;
              else if (!out_free) state_d = StWalk;
      StWrap: if (!h_ok) state_d = StEnd;
      StEnd:  if (out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      ovalid_q <= 1'b0;
      for (int i = 0; i < N; i++) begin
        next_q[i] <= (i + 1 < N) ? LW'(i + 1) : avpm_pkg::Nil;
        prev_q[i] <= (i == 0) ? avpm_pkg::Nil : LW'(i - 1);
      end
      used_q  <= '0;
      play_q  <= '0;
      loop_q  <= '0;
      ahead_q <= avpm_pkg::Nil;
      fhead_q <= '0;
      cnt_q   <= '0;
      fib_q   <= '0;
      mixl_q  <= '0;
      mixr_q  <= '0;
      h_q     <= '0;
      steps_q <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      if (out_ready_i) ovalid_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (take) begin
            ovalid_q     <= 1'b1;
            ores_q       <= '0;
            ores_q.kind  <= avpm_pkg::KindAck;
            ores_q.last  <= 1'b1;
            case (rq.op)
              avpm_pkg::OpAdd: begin
                if (cnt_q < LW'(N) && fhead_q < LW'(N)) begin
                  fhead_q <= next_q[fhead_q[VW-1:0]];
                  len_q[fhead_q[VW-1:0]]  <= rq.length;
                  pos_q[fhead_q[VW-1:0]]  <= '0;
                  play_q[fhead_q[VW-1:0]] <= rq.play;
                  loop_q[fhead_q[VW-1:0]] <= rq.loop;
                  used_q[fhead_q[VW-1:0]] <= 1'b1;
                  next_q[fhead_q[VW-1:0]] <= ahead_q;
                  prev_q[fhead_q[VW-1:0]] <= avpm_pkg::Nil;
                  if (ahead_q < LW'(N)) prev_q[ahead_q[VW-1:0]] <= fhead_q;
                  ahead_q      <= fhead_q;
                  cnt_q        <= cnt_q + LW'(1);
                  ores_q.ok    <= 1'b1;
                  ores_q.voice <= fhead_q[VW-1:0];
                end
              end
              avpm_pkg::OpRemove: begin
                ores_q.voice <= rq.voice;
                if (rq.vvalid && used_q[rq.voice]) begin
                  if (prev_q[rq.voice] < LW'(N))
                    next_q[prev_q[rq.voice][VW-1:0]] <= next_q[rq.voice];
                  else
                    ahead_q <= next_q[rq.voice];
                  if (next_q[rq.voice] < LW'(N))
                    prev_q[next_q[rq.voice][VW-1:0]] <= prev_q[rq.voice];
                  prev_q[rq.voice] <= avpm_pkg::Nil;
                  next_q[rq.voice] <= fhead_q;
                  fhead_q <= {1'b0, rq.voice};
                  used_q[rq.voice] <= 1'b0;
                  play_q[rq.voice] <= 1'b0;
                  if (cnt_q != '0) cnt_q <= cnt_q - LW'(1);
                  ores_q.ok <= 1'b1;
                end
              end
              avpm_pkg::OpPlay, avpm_pkg::OpPause, avpm_pkg::OpRestart: begin
                ores_q.voice <= rq.voice;
                ores_q.ok    <= rq.vvalid;
                if (rq.vvalid) begin
                  play_q[rq.voice] <= (rq.op == avpm_pkg::OpPlay);
                  if (rq.op == avpm_pkg::OpRestart) pos_q[rq.voice] <= '0;
                end
              end
              avpm_pkg::OpClear: begin
                for (int i = 0; i < N; i++) begin
                  next_q[i] <= (i + 1 < N) ? LW'(i + 1) : avpm_pkg::Nil;
                  prev_q[i] <= (i == 0) ? avpm_pkg::Nil : LW'(i - 1);
                end
                used_q  <= '0;
                play_q  <= '0;
                loop_q  <= '0;
                ahead_q <= avpm_pkg::Nil;
                fhead_q <= '0;
                cnt_q   <= '0;
                ores_q.ok <= 1'b1;
              end
              avpm_pkg::OpFrame: begin
                ovalid_q <= 1'b0;
                mixl_q   <= '0;
                mixr_q   <= '0;
                h_q      <= ahead_q;
                steps_q  <= '0;
                idx_q    <= fib_q;
              end
              avpm_pkg::OpSample: begin
                ores_q.kind      <= avpm_pkg::KindMix;
                ores_q.ok        <= 1'b1;
                ores_q.mix_left  <= avpm_pkg::sat_add16(mixl_q, rq.left);
                ores_q.mix_right <= avpm_pkg::sat_add16(mixr_q, rq.right);
                mixl_q <= avpm_pkg::sat_add16(mixl_q, rq.left);
                mixr_q <= avpm_pkg::sat_add16(mixr_q, rq.right);
              end
              default: ;
            endcase
          end
        end
        StWalk: begin
          if (!h_ok) begin
            h_q     <= ahead_q;
            steps_q <= '0;
            if (fib_inc >= eff) fib_q <= '0;
            else fib_q <= fib_inc[avpm_pkg::FibW-1:0];
          end else if (out_free) begin
            if (play_q[hv] && pos_q[hv] < len_q[hv]) begin
              ovalid_q        <= 1'b1;
              ores_q          <= '0;
              ores_q.kind     <= avpm_pkg::KindFetch;
              ores_q.ok       <= 1'b1;
              ores_q.voice    <= hv;
              ores_q.position <= pos_q[hv];
              pos_q[hv]       <= pos_q[hv] + PW'(1);
            end
            h_q     <= next_q[hv];
            steps_q <= steps_q + LW'(1);
          end
        end
        StWrap: begin
          if (h_ok) begin
            if (play_q[hv] && pos_q[hv] >= len_q[hv]) begin
              pos_q[hv] <= '0;
              if (!loop_q[hv]) play_q[hv] <= 1'b0;
            end
            h_q     <= next_q[hv];
            steps_q <= steps_q + LW'(1);
          end
        end
        StEnd: begin
          if (out_free) begin
            ovalid_q        <= 1'b1;
            ores_q          <= '0;
            ores_q.kind     <= avpm_pkg::KindEnd;
            ores_q.ok       <= 1'b1;
            ores_q.position <= PW'(idx_q);
            ores_q.last     <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: tb/audio_voice_pool_mixer_checker.sv
`timescale 1ns / 100ps
// Checker for the voice pool mixer: tracks voice lists, predicts results and compares them.
module audio_voice_pool_mixer_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [avpm_pkg::FpbW-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [2:0]                    op_i,
  input  logic [avpm_pkg::VoiceW-1:0]   voice_i,
  input  logic [avpm_pkg::PosW-1:0]     length_frames_i,
  input  logic                          start_playing_i,
  input  logic                          loop_enable_i,
  input  logic signed [15:0]            sample_left_i,
  input  logic signed [15:0]            sample_right_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [1:0]                    kind_i,
  input  logic                          ok_i,
  input  logic [avpm_pkg::VoiceW-1:0]   voice_out_i,
  input  logic [avpm_pkg::PosW-1:0]     position_i,
  input  logic signed [15:0]            mix_left_i,
  input  logic signed [15:0]            mix_right_i,
  input  logic                          last_i,
  output int                            fail_count_o,
  output int                            pending_o,
  output int                            requests_o,
  output int                            results_o
);

  logic [avpm_pkg::LinkW-1:0] link_next [avpm_pkg::Voices];
  logic [avpm_pkg::LinkW-1:0] link_prev [avpm_pkg::Voices];
  bit                         busy_voice [avpm_pkg::Voices];
  bit                         playing [avpm_pkg::Voices];
  bit                         looping [avpm_pkg::Voices];
  logic [avpm_pkg::PosW-1:0]  wave_len [avpm_pkg::Voices];
  logic [avpm_pkg::PosW-1:0]  play_pos [avpm_pkg::Voices];
  logic [avpm_pkg::LinkW-1:0] active_head, free_head;
  int                         voices_used;
  int                         frame_idx;
  logic signed [15:0]         mix_l, mix_r;
  int                         buf_frames;
  avpm_pkg::res_t             expected_q[$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    requests_o   = 0;
    results_o    = 0;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    fail_count_o++;
  endtask

  task automatic rebuild_free_list();
    for (int i = 0; i < avpm_pkg::Voices; i++) begin
      link_next[i]  = (i + 1 < avpm_pkg::Voices) ? avpm_pkg::LinkW'(i + 1) : avpm_pkg::Nil;
      link_prev[i]  = (i == 0) ? avpm_pkg::Nil : avpm_pkg::LinkW'(i - 1);
      busy_voice[i] = 0;
      playing[i]    = 0;
      looping[i]    = 0;
    end
    active_head = avpm_pkg::Nil;
    free_head   = '0;
    voices_used = 0;
  endtask

  function automatic logic signed [15:0] clamp_sum(logic signed [15:0] a,
                                                   logic signed [15:0] b);
    int s;
    s = int'(a) + int'(b);
    if (s > 32767) s = 32767;
    if (s < -32768) s = -32768;
    return s[15:0];
  endfunction

  task automatic push_result(input avpm_pkg::kind_e k, input logic ok,
                             input logic [avpm_pkg::VoiceW-1:0] v,
                             input logic [avpm_pkg::PosW-1:0] pos,
                             input logic signed [15:0] l,
                             input logic signed [15:0] r, input logic fin);
    avpm_pkg::res_t e;
    e.kind = k; e.ok = ok; e.voice = v; e.position = pos;
    e.mix_left = l; e.mix_right = r; e.last = fin;
    expected_q.push_back(e);
  endtask

  // Works out the results of one request and updates the shadow state.
  task automatic predict_request();
    logic [avpm_pkg::LinkW-1:0]  h, p, q;
    logic [avpm_pkg::VoiceW-1:0] hv;
    int                          steps, limit;
    logic [avpm_pkg::PosW-1:0]   idx;
    avpm_pkg::op_e               op;
    op = avpm_pkg::op_e'(op_i);
    case (op)
      avpm_pkg::OpAdd: begin
        h = free_head;
        if (voices_used >= int'(avpm_pkg::Voices) || h >= avpm_pkg::Voices) begin
          push_result(avpm_pkg::KindAck, 0, '0, '0, '0, '0, 1);
        end else begin
          hv             = h[avpm_pkg::VoiceW-1:0];
          free_head      = link_next[hv];
          wave_len[hv]   = length_frames_i;
          play_pos[hv]   = '0;
          playing[hv]    = start_playing_i;
          looping[hv]    = loop_enable_i;
          busy_voice[hv] = 1;
          link_next[hv]  = active_head;
          link_prev[hv]  = avpm_pkg::Nil;
          if (active_head < avpm_pkg::Voices)
            link_prev[active_head[avpm_pkg::VoiceW-1:0]] = h;
          active_head = h;
          voices_used++;
          push_result(avpm_pkg::KindAck, 1, hv, '0, '0, '0, 1);
        end
      end
      avpm_pkg::OpRemove: begin
        if (!busy_voice[voice_i]) begin
          push_result(avpm_pkg::KindAck, 0, voice_i, '0, '0, '0, 1);
        end else begin
          p = link_prev[voice_i];
          q = link_next[voice_i];
          if (p < avpm_pkg::Voices) link_next[p[avpm_pkg::VoiceW-1:0]] = q;
          else active_head = q;
          if (q < avpm_pkg::Voices) link_prev[q[avpm_pkg::VoiceW-1:0]] = p;
          link_prev[voice_i]  = avpm_pkg::Nil;
          link_next[voice_i]  = free_head;
          free_head           = {1'b0, voice_i};
          busy_voice[voice_i] = 0;
          playing[voice_i]    = 0;
          if (voices_used > 0) voices_used--;
          push_result(avpm_pkg::KindAck, 1, voice_i, '0, '0, '0, 1);
        end
      end
      avpm_pkg::OpPlay, avpm_pkg::OpPause, avpm_pkg::OpRestart: begin
        // Free voices are accepted too; add sets the flags again later.
        playing[voice_i] = (op == avpm_pkg::OpPlay);
        if (op == avpm_pkg::OpRestart) play_pos[voice_i] = '0;
        push_result(avpm_pkg::KindAck, 1, voice_i, '0, '0, '0, 1);
      end
      avpm_pkg::OpClear: begin
        rebuild_free_list();
        push_result(avpm_pkg::KindAck, 1, '0, '0, '0, '0, 1);
      end
      avpm_pkg::OpFrame: begin
        mix_l = '0;
        mix_r = '0;
        h = active_head;
        steps = 0;
        while (h < avpm_pkg::Voices && steps < int'(avpm_pkg::Voices)) begin
          hv = h[avpm_pkg::VoiceW-1:0];
          if (playing[hv] && play_pos[hv] < wave_len[hv]) begin
            push_result(avpm_pkg::KindFetch, 1, hv, play_pos[hv], '0, '0, 0);
            play_pos[hv] = play_pos[hv] + 1'b1;
          end
          h = link_next[hv];
          steps++;
        end
        limit = (buf_frames == 0) ? 1 : (buf_frames > 4096) ? 4096 : buf_frames;
        idx = avpm_pkg::PosW'(frame_idx);
        frame_idx++;
        if (frame_idx >= limit) begin
          // Buffer end: finished voices wrap when looping, else stop and rewind.
          frame_idx = 0;
          h = active_head;
          steps = 0;
          while (h < avpm_pkg::Voices && steps < int'(avpm_pkg::Voices)) begin
            hv = h[avpm_pkg::VoiceW-1:0];
            if (playing[hv] && play_pos[hv] >= wave_len[hv]) begin
              play_pos[hv] = '0;
              if (!looping[hv]) playing[hv] = 0;
            end
            h = link_next[hv];
            steps++;
          end
        end
        push_result(avpm_pkg::KindEnd, 1, '0, idx, '0, '0, 1);
      end
      default: begin
        mix_l = clamp_sum(mix_l, sample_left_i);
        mix_r = clamp_sum(mix_r, sample_right_i);
        push_result(avpm_pkg::KindMix, 1, '0, '0, mix_l, mix_r, 1);
      end
    endcase
  endtask

  task automatic compare_result();
    avpm_pkg::res_t e;
    if (expected_q.size() == 0) begin
      report_mismatch($sformatf("result kind %0d with nothing expected", kind_i));
    end else begin
      e = expected_q.pop_front();
      if (kind_i != e.kind)
        report_mismatch($sformatf("kind %0d, expected %0d", kind_i, e.kind));
      if (ok_i != e.ok)
        report_mismatch($sformatf("ok %0d, expected %0d", ok_i, e.ok));
      if (voice_out_i != e.voice)
        report_mismatch($sformatf("voice %0d, expected %0d", voice_out_i, e.voice));
      if (position_i != e.position)
        report_mismatch($sformatf("position %0d, expected %0d", position_i, e.position));
      if (mix_left_i != e.mix_left)
        report_mismatch($sformatf("mix_left %0d, expected %0d", mix_left_i, e.mix_left));
      if (mix_right_i != e.mix_right)
        report_mismatch($sformatf("mix_right %0d, expected %0d", mix_right_i, e.mix_right));
      if (last_i != e.last)
        report_mismatch($sformatf("last %0d, expected %0d", last_i, e.last));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rebuild_free_list();
      for (int i = 0; i < avpm_pkg::Voices; i++) begin
        wave_len[i] = '0;
        play_pos[i] = '0;
      end
      frame_idx  = 0;
      mix_l      = '0;
      mix_r      = '0;
      buf_frames = int'(avpm_pkg::FpbReset);
      expected_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        compare_result();
        results_o++;
      end
      if (cfg_we_i) buf_frames = int'(cfg_wdata_i);
      if (in_valid_i && in_ready_i) begin
        predict_request();
        requests_o++;
      end
    end
    pending_o = expected_q.size();
  end

  final begin
    if (expected_q.size() != 0)
      $display("%0d results never arrived", expected_q.size());
  end

endmodule

FILE: tb/audio_voice_pool_mixer_tb.sv
`timescale 1ns / 100ps
// Top of the voice pool mixer testbench: clock, reset, stimulus and verdict.
module audio_voice_pool_mixer_tb;

  logic                               clk_i;
  logic                               rst_ni;
  logic                               cfg_we;
  logic [avpm_pkg::FpbW-1:0]          cfg_wdata;
  logic                               in_valid, in_ready;
  logic [2:0]                         op;
  logic [avpm_pkg::VoiceW-1:0]        voice;
  logic [avpm_pkg::PosW-1:0]          length_frames;
  logic                               start_playing, loop_enable;
  logic signed [15:0]                 sample_left, sample_right;
  logic                               out_valid, out_ready;
  logic [1:0]                         kind;
  logic                               ok, last;
  logic [avpm_pkg::VoiceW-1:0]        voice_out;
  logic [avpm_pkg::PosW-1:0]          position;
  logic signed [15:0]                 mix_left, mix_right;
  int                                 fail_count, pending, requests, results;

  // When quiet is set both sides run without gaps; hold_req asks the
  // receiver for one long stall.
  bit quiet;
  bit hold_req;

  audio_voice_pool_mixer dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .op_i(op), .voice_i(voice), .length_frames_i(length_frames),
    .start_playing_i(start_playing), .loop_enable_i(loop_enable),
    .sample_left_i(sample_left), .sample_right_i(sample_right),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .kind_o(kind), .ok_o(ok), .voice_out_o(voice_out), .position_o(position),
    .mix_left_o(mix_left), .mix_right_o(mix_right), .last_o(last)
  );

  audio_voice_pool_mixer_checker checker_i (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .op_i(op), .voice_i(voice), .length_frames_i(length_frames),
    .start_playing_i(start_playing), .loop_enable_i(loop_enable),
    .sample_left_i(sample_left), .sample_right_i(sample_right),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .kind_i(kind), .ok_i(ok), .voice_out_i(voice_out), .position_i(position),
    .mix_left_i(mix_left), .mix_right_i(mix_right), .last_i(last),
    .fail_count_o(fail_count), .pending_o(pending),
    .requests_o(requests), .results_o(results)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // The run is cut off well beyond the slowest correct run.
  initial begin
    #800000;
    $display("timeout with %0d results outstanding", pending);
    $display("audio_voice_pool_mixer_tb: FAIL");
    $finish;
  end

  function automatic logic [avpm_pkg::VoiceW-1:0] pick_voice();
    return avpm_pkg::VoiceW'($urandom_range(0, 15));
  endfunction

  // Sends one request. The gap before it is drawn first; with no gap the
  // valid stays high from the previous request, so it is never dropped and
  // raised in the same step.
  task automatic send_request(input avpm_pkg::op_e o, input logic [avpm_pkg::VoiceW-1:0] v,
                              input logic [avpm_pkg::PosW-1:0] len, input logic play,
                              input logic lp, input logic signed [15:0] l,
                              input logic signed [15:0] r);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    op            <= o;
    voice         <= v;
    length_frames <= len;
    start_playing <= play;
    loop_enable   <= lp;
    sample_left   <= l;
    sample_right  <= r;
    in_valid      <= 1'b1;
    do @(posedge clk_i); while (!in_ready);
  endtask

  // Drops valid and waits until every expected result has come back, then
  // lets the block settle before anything else changes.
  task automatic drain_block();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // The register is written only while the block is idle.
  task automatic write_buffer_size(input int frames);
    drain_block();
    cfg_we    <= 1'b1;
    cfg_wdata <= avpm_pkg::FpbW'(frames);
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_ack_op(input avpm_pkg::op_e o, input logic [avpm_pkg::VoiceW-1:0] v);
    send_request(o, v, '0, 1'b0, 1'b0, '0, '0);
  endtask

  task automatic send_add(input logic [avpm_pkg::PosW-1:0] len, input logic play,
                          input logic lp);
    send_request(avpm_pkg::OpAdd, pick_voice(), len, play, lp, 16'($urandom),
                 16'($urandom));
  endtask

  function automatic logic signed [15:0] pick_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'sh7fff;
    if (r == 1) return 16'sh8000;
    return 16'($urandom);
  endfunction

  task automatic send_random_sample();
    send_request(avpm_pkg::OpSample, pick_voice(), avpm_pkg::PosW'($urandom),
                 1'($urandom), 1'($urandom), pick_sample(), pick_sample());
  endtask

  // A frame followed by a few samples is the common well-formed sequence.
  task automatic send_frame_with_samples();
    send_ack_op(avpm_pkg::OpFrame, pick_voice());
    repeat ($urandom_range(0, 4)) send_random_sample();
  endtask

  task automatic random_request();
    int r;
    logic [avpm_pkg::PosW-1:0] len;
    r = $urandom_range(0, 99);
    len = ($urandom_range(0, 4) == 0) ? avpm_pkg::PosW'($urandom) :
                                        avpm_pkg::PosW'($urandom_range(0, 5));
    if (r < 22) send_add(len, 1'($urandom), 1'($urandom));
    else if (r < 32) send_ack_op(avpm_pkg::OpRemove, pick_voice());
    else if (r < 40) send_ack_op(avpm_pkg::OpPlay, pick_voice());
    else if (r < 46) send_ack_op(avpm_pkg::OpPause, pick_voice());
    else if (r < 52) send_ack_op(avpm_pkg::OpRestart, pick_voice());
    else if (r < 54) send_ack_op(avpm_pkg::OpClear, pick_voice());
    else if (r < 85) send_frame_with_samples();
    else send_random_sample();
  endtask

  // Receiver: a random stall before each result, plus one long stall on request.
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        stall = quiet ? 0 : $urandom_range(0, 11);
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!(out_valid && out_ready));
    end
  end

  initial begin
    int sizes[5] = '{1, 0, 8191, 4096, 3};
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    op            = avpm_pkg::OpClear;
    voice         = '0;
    length_frames = '0;
    start_playing = 1'b0;
    loop_enable   = 1'b0;
    sample_left   = '0;
    sample_right  = '0;
    quiet         = 1'b0;
    hold_req      = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset buffer size: control of free voices, the
    // field extremes, a looping zero-length voice and mix saturation.
    send_ack_op(avpm_pkg::OpPlay, 4'd15);
    send_ack_op(avpm_pkg::OpPause, 4'd15);
    send_ack_op(avpm_pkg::OpRestart, 4'd0);
    send_ack_op(avpm_pkg::OpRemove, 4'd3);
    send_add(24'd0, 1'b1, 1'b1);
    send_add(24'hffffff, 1'b1, 1'b0);
    send_add(24'd2, 1'b1, 1'b0);
    send_add(24'd1, 1'b0, 1'b1);
    send_ack_op(avpm_pkg::OpFrame, 4'd0);
    send_request(avpm_pkg::OpSample, 4'd0, '0, 1'b0, 1'b0, 16'sh7fff, 16'sh8000);
    send_request(avpm_pkg::OpSample, 4'd0, '0, 1'b0, 1'b0, 16'sh7fff, 16'sh8000);
    send_request(avpm_pkg::OpSample, 4'd0, '0, 1'b0, 1'b0, -16'sd1, 16'sd1);
    send_ack_op(avpm_pkg::OpRemove, 4'd2);
    send_ack_op(avpm_pkg::OpRemove, 4'd2);
    send_ack_op(avpm_pkg::OpPlay, 4'd3);
    send_ack_op(avpm_pkg::OpFrame, 4'd0);
    send_ack_op(avpm_pkg::OpClear, 4'd0);

    // Fill the pool and push one more add, which must fail.
    quiet = 1'b1;
    repeat (17) send_add(avpm_pkg::PosW'($urandom_range(1, 40)), 1'b1, 1'($urandom));
    quiet = 1'b0;

    // Long receiver stall while frames over a full pool keep coming, so the
    // block backs up and holds its input.
    hold_req = 1'b1;
    repeat (8) send_ack_op(avpm_pkg::OpFrame, pick_voice());
    drain_block();

    // Random phases over several buffer sizes, one of them with no gaps.
    foreach (sizes[i]) begin
      write_buffer_size(sizes[i]);
      quiet = (i == 2);
      repeat (10) random_request();
    end
    quiet = 1'b0;
    repeat (6) send_ack_op(avpm_pkg::OpFrame, pick_voice());

    drain_block();
    $display("covered %0d requests and %0d results over buffer sizes 512, 1, 0, 8191,",
             requests, results);
    $display("4096 and 3, with a full pool, a long output stall and gap-free stretches");
    if (fail_count == 0) begin
      $display("audio_voice_pool_mixer_tb: PASS");
    end else begin
      $display("audio_voice_pool_mixer_tb: FAIL");
    end
    $finish;
  end

endmodule
